### sv/time_sync_client_registry_macros.svh
// Assertion macros used by the client registry engine.
`ifndef TIME_SYNC_CLIENT_REGISTRY_MACROS_SVH
`define TIME_SYNC_CLIENT_REGISTRY_MACROS_SVH

`ifndef SYNTHESIS
`define TSCR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define TSCR_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define TSCR_ASSERT(lbl, prop, msg)
`define TSCR_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

### sv/tscr_pkg.sv
// Shared types and constants of the time sync client registry.
`timescale 1ns / 1ps

package tscr_pkg;

   // Table size and forward limit.
   localparam int MAX_CLIENTS = 16;
   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   // Depth of the queue between the classifier and the engine.
   localparam int QUEUE_DEPTH = 2;

   // Register reset values.
   localparam logic [31:0] IDLE_TIMEOUT_RESET = 32'd120000;
   localparam logic [63:0] PLAYHEAD_CODE_RESET = {64{1'b1}};

   // Result kinds.
   localparam logic KIND_REPLY   = 1'b0;
   localparam logic KIND_FORWARD = 1'b1;

   // Input modes.
   localparam logic MODE_DATAGRAM = 1'b0;
   localparam logic MODE_SWEEP    = 1'b1;

   // Register indexes (bit 3 of the byte address).
   localparam logic REG_IDLE_TIMEOUT = 1'b0;
   localparam logic REG_PLAYHEAD_CODE = 1'b1;

   // Classified item handed from the front to the engine.
   typedef struct packed {
      logic               is_sweep;
      logic               is_cmd;
      logic [31:0]        sender_address;
      logic [15:0]        sender_port;
      logic signed [63:0] server_stamp_in;
      logic signed [63:0] client_stamp_in;
      logic [62:0]        now_ms;
      logic signed [63:0] round_trip;
   } tscr_item_type;

   // Engine states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_REPLY,
      ST_FWD,
      ST_SWEEP
   } tscr_state_type;

endpackage

### sv/tscr_req_if.sv
// Input channel carrying datagram and sweep items.
`timescale 1ns / 1ps

interface tscr_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic               length_ok;
   logic [31:0]        sender_address;
   logic [15:0]        sender_port;
   logic signed [63:0] server_stamp_in;
   logic signed [63:0] client_stamp_in;
   logic [62:0]        now_ms;

   modport source (output valid, mode, length_ok, sender_address, sender_port,
                   server_stamp_in, client_stamp_in, now_ms, input ready);
   modport sink (input valid, mode, length_ok, sender_address, sender_port,
                 server_stamp_in, client_stamp_in, now_ms, output ready);
endinterface

### sv/tscr_rsp_if.sv
// Result channel carrying replies and forwarded commands.
`timescale 1ns / 1ps

interface tscr_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [31:0]        dest_address;
   logic [15:0]        dest_port;
   logic signed [63:0] server_stamp_out;
   logic signed [63:0] client_stamp_out;
   logic signed [63:0] round_trip;
   logic               table_full;
   logic               last;

   modport source (output valid, kind, dest_address, dest_port, server_stamp_out,
                   client_stamp_out, round_trip, table_full, last, input ready);
   modport sink (input valid, kind, dest_address, dest_port, server_stamp_out,
                 client_stamp_out, round_trip, table_full, last, output ready);
endinterface

### sv/tscr_front.sv
// Front end: accepts items, drops bad datagrams and classifies the rest.
`timescale 1ns / 1ps

module tscr_front (
   tscr_req_if.sink              req_if,
   input  logic [63:0]           playhead_code,
   input  logic                  queue_full,
   output logic                  push,
   output tscr_pkg::tscr_item_type item
);

   // Accept whenever the queue has room; only useful items are queued.
   assign req_if.ready = !queue_full;
   assign push = req_if.valid && !queue_full &&
                 ((req_if.mode == tscr_pkg::MODE_SWEEP) || req_if.length_ok);

   // Classify the item and precompute the round trip of a reply.
   always_comb begin
      item.is_sweep        = (req_if.mode == tscr_pkg::MODE_SWEEP);
      item.is_cmd          = (req_if.server_stamp_in == playhead_code);
      item.sender_address  = req_if.sender_address;
      item.sender_port     = req_if.sender_port;
      item.server_stamp_in = req_if.server_stamp_in;
      item.client_stamp_in = req_if.client_stamp_in;
      item.now_ms          = req_if.now_ms;
      item.round_trip      = {1'b0, req_if.now_ms} - req_if.server_stamp_in;
   end

endmodule

### sv/tscr_queue.sv
// Short queue that decouples the front end from the engine.
`timescale 1ns / 1ps

module tscr_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  tscr_pkg::tscr_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    not_empty,
   output tscr_pkg::tscr_item_type pop_item
);

   localparam int PTR_W = (tscr_pkg::QUEUE_DEPTH > 1) ? $clog2(tscr_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(tscr_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(tscr_pkg::QUEUE_DEPTH - 1);

   tscr_pkg::tscr_item_type slot_ff [tscr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign full      = (fill_ff == CNT_W'(tscr_pkg::QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Item storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### sv/tscr_engine.sv
// Engine: client table, lookup, forwarding and sweeping, one entry per cycle unless forwards stall.
`timescale 1ns / 1ps
`include "time_sync_client_registry_macros.svh"

module tscr_engine #(
   parameter int MaxClients = tscr_pkg::MAX_CLIENTS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  tscr_pkg::tscr_item_type item,
   output logic                    item_pop,
   input  logic [31:0]             idle_timeout_ms,
   tscr_rsp_if.source              rsp_if
);

   localparam int CNT_W = $clog2(MaxClients + 1);
   localparam int IDX_W = (MaxClients > 1) ? $clog2(MaxClients) : 1;
   localparam int CW    = (CNT_W > tscr_pkg::RES_CNT_W) ? CNT_W : tscr_pkg::RES_CNT_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MaxClients);
   localparam logic [CW-1:0]    RES_LIMIT  = CW'(tscr_pkg::MAX_RESULTS);

   tscr_pkg::tscr_state_type state_ff, state_in;
   tscr_pkg::tscr_item_type  cur_ff, cur_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] keep_ff, keep_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] hit_ff, hit_in;
   logic             found_ff, found_in;
   logic             full_ff, full_in;
   logic             in_table_ff, in_table_in;
   logic [CW-1:0]    cap_ff, cap_in;
   logic [CW-1:0]    sent_ff, sent_in;
   logic [63:0]      playhead_ff, playhead_in;

   // Client table.
   logic [31:0] addr_mem [MaxClients];
   logic [15:0] port_mem [MaxClients];
   logic [62:0] seen_mem [MaxClients];

   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [31:0]      wr_addr;
   logic [15:0]      wr_port;
   logic [62:0]      wr_seen;

   // Output register.
   logic               out_valid_ff, out_valid_in;
   logic               load;
   logic               out_kind_ff, out_kind_in;
   logic [31:0]        out_addr_ff, out_addr_in;
   logic [15:0]        out_port_ff, out_port_in;
   logic signed [63:0] out_ss_ff, out_ss_in;
   logic signed [63:0] out_cs_ff, out_cs_in;
   logic signed [63:0] out_rtt_ff, out_rtt_in;
   logic               out_full_ff, out_full_in;
   logic               out_last_ff, out_last_in;

   // Table read at the scan position.
   logic [31:0]        rd_addr;
   logic [15:0]        rd_port;
   logic [62:0]        rd_seen;
   logic               at_end;
   logic               match;
   logic               can_load;
   logic               appended;
   logic [CNT_W-1:0]   fwd_total;
   logic [CW-1:0]      fwd_total_w;
   logic signed [63:0] idle_time;
   logic               keep_entry;
   logic               is_sender;
   logic               fwd_last;

   assign rd_addr  = addr_mem[idx_ff[IDX_W-1:0]];
   assign rd_port  = port_mem[idx_ff[IDX_W-1:0]];
   assign rd_seen  = seen_mem[idx_ff[IDX_W-1:0]];
   assign at_end   = (idx_ff == count_ff);
   assign match    = (rd_addr == cur_ff.sender_address) && (rd_port == cur_ff.sender_port);
   assign can_load = !out_valid_ff || rsp_if.ready;

   // Sender is appended when new and the table has room.
   assign appended    = !found_ff && (count_ff < FULL_COUNT);
   assign fwd_total   = found_ff ? count_ff - 1'b1 : count_ff;
   assign fwd_total_w = CW'(fwd_total);

   // Idle time of the scanned entry; both times are below 2^63.
   assign idle_time  = {1'b0, cur_ff.now_ms} - {1'b0, rd_seen};
   assign keep_entry = idle_time < $signed({32'd0, idle_timeout_ms});

   assign is_sender = in_table_ff && (idx_ff == hit_ff);
   assign fwd_last  = ((sent_ff + 1'b1) == cap_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tscr_pkg::ST_IDLE: begin
            if (item_valid) begin
               state_in = item.is_sweep ? tscr_pkg::ST_SWEEP : tscr_pkg::ST_LOOKUP;
            end
         end
         tscr_pkg::ST_LOOKUP: begin
            if (at_end || match) begin
               state_in = tscr_pkg::ST_UPDATE;
            end
         end
         tscr_pkg::ST_UPDATE: begin
            if (!cur_ff.is_cmd) begin
               state_in = tscr_pkg::ST_REPLY;
            end else if (cur_ff.client_stamp_in == playhead_ff || fwd_total == '0) begin
               state_in = tscr_pkg::ST_IDLE;
            end else begin
               state_in = tscr_pkg::ST_FWD;
            end
         end
         tscr_pkg::ST_REPLY: begin
            if (can_load) begin
               state_in = tscr_pkg::ST_IDLE;
            end
         end
         tscr_pkg::ST_FWD: begin
            if (at_end) begin
               state_in = tscr_pkg::ST_IDLE;
            end else if (!is_sender && can_load && fwd_last) begin
               state_in = tscr_pkg::ST_IDLE;
            end
         end
         tscr_pkg::ST_SWEEP: begin
            if (at_end) begin
               state_in = tscr_pkg::ST_IDLE;
            end
         end
         default: state_in = tscr_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls and register next values.
   always_comb begin
      item_pop    = 1'b0;
      cur_in      = cur_ff;
      idx_in      = idx_ff;
      keep_in     = keep_ff;
      count_in    = count_ff;
      hit_in      = hit_ff;
      found_in    = found_ff;
      full_in     = full_ff;
      in_table_in = in_table_ff;
      cap_in      = cap_ff;
      sent_in     = sent_ff;
      playhead_in = playhead_ff;
      wr_en       = 1'b0;
      wr_idx      = idx_ff[IDX_W-1:0];
      wr_addr     = rd_addr;
      wr_port     = rd_port;
      wr_seen     = rd_seen;
      load        = 1'b0;
      out_kind_in = tscr_pkg::KIND_REPLY;
      out_addr_in = cur_ff.sender_address;
      out_port_in = cur_ff.sender_port;
      out_ss_in   = $signed({1'b0, cur_ff.now_ms});
      out_cs_in   = cur_ff.client_stamp_in;
      out_rtt_in  = cur_ff.round_trip;
      out_full_in = full_ff;
      out_last_in = 1'b1;
      unique case (state_ff)
         tscr_pkg::ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               cur_in   = item;
               idx_in   = '0;
               keep_in  = '0;
               found_in = 1'b0;
            end
         end
         tscr_pkg::ST_LOOKUP: begin
            if (!at_end && match) begin
               found_in = 1'b1;
               hit_in   = idx_ff;
            end else if (!at_end) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         tscr_pkg::ST_UPDATE: begin
            // Refresh, append or flag the table as full.
            wr_addr     = cur_ff.sender_address;
            wr_port     = cur_ff.sender_port;
            wr_seen     = cur_ff.now_ms;
            wr_en       = found_ff || appended;
            wr_idx      = found_ff ? hit_ff[IDX_W-1:0] : count_ff[IDX_W-1:0];
            hit_in      = found_ff ? hit_ff : count_ff;
            in_table_in = found_ff || appended;
            full_in     = !found_ff && !appended;
            count_in    = appended ? count_ff + 1'b1 : count_ff;
            cap_in      = (fwd_total_w > RES_LIMIT) ? RES_LIMIT : fwd_total_w;
            sent_in     = '0;
            idx_in      = '0;
            if (cur_ff.is_cmd && cur_ff.client_stamp_in != playhead_ff) begin
               playhead_in = cur_ff.client_stamp_in;
            end
         end
         tscr_pkg::ST_REPLY: begin
            load = can_load;
         end
         tscr_pkg::ST_FWD: begin
            if (!at_end && is_sender) begin
               idx_in = idx_ff + 1'b1;
            end else if (!at_end && can_load) begin
               load        = 1'b1;
               out_kind_in = tscr_pkg::KIND_FORWARD;
               out_addr_in = rd_addr;
               out_port_in = rd_port;
               out_ss_in   = cur_ff.server_stamp_in;
               out_rtt_in  = '0;
               out_last_in = fwd_last;
               sent_in     = sent_ff + 1'b1;
               idx_in      = idx_ff + 1'b1;
            end
         end
         tscr_pkg::ST_SWEEP: begin
            // Compact the surviving entries toward the front.
            if (at_end) begin
               count_in = keep_ff;
            end else begin
               idx_in = idx_ff + 1'b1;
               if (keep_entry) begin
                  wr_en   = 1'b1;
                  wr_idx  = keep_ff[IDX_W-1:0];
                  keep_in = keep_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign out_valid_in = load ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tscr_pkg::ST_IDLE;
         count_ff     <= '0;
         playhead_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         playhead_ff  <= playhead_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Working registers of the current item.
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      keep_ff     <= keep_in;
      hit_ff      <= hit_in;
      found_ff    <= found_in;
      full_ff     <= full_in;
      in_table_ff <= in_table_in;
      cap_ff      <= cap_in;
      sent_ff     <= sent_in;
   end

   // Table write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         addr_mem[wr_idx] <= wr_addr;
         port_mem[wr_idx] <= wr_port;
         seen_mem[wr_idx] <= wr_seen;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load) begin
         out_kind_ff <= out_kind_in;
         out_addr_ff <= out_addr_in;
         out_port_ff <= out_port_in;
         out_ss_ff   <= out_ss_in;
         out_cs_ff   <= out_cs_in;
         out_rtt_ff  <= out_rtt_in;
         out_full_ff <= out_full_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_if.valid            = out_valid_ff;
   assign rsp_if.kind             = out_kind_ff;
   assign rsp_if.dest_address     = out_addr_ff;
   assign rsp_if.dest_port        = out_port_ff;
   assign rsp_if.server_stamp_out = out_ss_ff;
   assign rsp_if.client_stamp_out = out_cs_ff;
   assign rsp_if.round_trip       = out_rtt_ff;
   assign rsp_if.table_full       = out_full_ff;
   assign rsp_if.last             = out_last_ff;

   // The table never holds more clients than it has slots.
   `TSCR_ASSERT(a_count_bound, count_ff <= FULL_COUNT, "client count above table size")
   // Items leave the queue only when the engine is free.
   `TSCR_ASSERT(a_pop_idle, item_pop |-> state_ff == tscr_pkg::ST_IDLE, "pop while busy")
   // Forwarding stops at the computed number of results.
   `TSCR_ASSERT(a_fwd_cap, state_ff == tscr_pkg::ST_FWD |-> sent_ff < cap_ff, "too many forwards")
   // A sweep never grows the table.
   `TSCR_ASSERT(a_sweep_shrink, (state_ff == tscr_pkg::ST_SWEEP) && at_end |=>
      count_ff <= $past(count_ff), "sweep grew the table")

endmodule

### sv/time_sync_client_registry.sv
// Top level of the time sync client registry: registers, front end, queue and engine.
//
// Usage: items enter on req_if (valid/ready). A datagram item (mode 0) registers
// its sender if the table has room and yields one ping reply or a burst, possibly
// empty, of forwarded playhead commands on rsp_if; "last" marks the final result
// of an item. Wrong-length datagrams and sweep items (mode 1) yield no result.
// Operation: the engine scans the client table one entry per cycle, except that a
// stalled receiver holds the forward scan. It takes an item from the queue only when
// idle, looks the sender up in the table, updates the table, then loads a reply or
// scans the table to forward. A sweep scans every entry once, keeping the live ones.
// A two-entry queue lets the front end accept items while the engine works.
// Registers sit on an APB-style port: idle timeout at 0x0, command code at 0x8.
// Reset empties the table, clears the playhead time and loads register defaults.
// When the receiver stalls, the result stays in the output register and the
// engine holds; once the queue fills, req_if.ready drops.
`timescale 1ns / 1ps

module time_sync_client_registry #(
   parameter int MaxClients = tscr_pkg::MAX_CLIENTS
) (
   input  logic        clock,
   input  logic        reset,
   tscr_req_if.sink    req_if,
   tscr_rsp_if.source  rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   logic [31:0] idle_timeout_ff, idle_timeout_in;
   logic [63:0] playhead_code_ff, playhead_code_in;
   logic        cfg_write;

   logic                    push;
   logic                    queue_full;
   logic                    queue_valid;
   logic                    pop;
   tscr_pkg::tscr_item_type front_item;
   tscr_pkg::tscr_item_type queue_item;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   // Register writes, selected by bit 3 of the byte address.
   always_comb begin
      idle_timeout_in  = idle_timeout_ff;
      playhead_code_in = playhead_code_ff;
      if (cfg_write) begin
         unique case (paddr[3])
            tscr_pkg::REG_IDLE_TIMEOUT:  idle_timeout_in  = pwdata[31:0];
            tscr_pkg::REG_PLAYHEAD_CODE: playhead_code_in = pwdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_timeout_ff  <= tscr_pkg::IDLE_TIMEOUT_RESET;
         playhead_code_ff <= tscr_pkg::PLAYHEAD_CODE_RESET;
      end else begin
         idle_timeout_ff  <= idle_timeout_in;
         playhead_code_ff <= playhead_code_in;
      end
   end

   // Register reads.
   always_comb begin
      unique case (paddr[3])
         tscr_pkg::REG_IDLE_TIMEOUT:  prdata = {32'd0, idle_timeout_ff};
         tscr_pkg::REG_PLAYHEAD_CODE: prdata = playhead_code_ff;
         default:                     prdata = '0;
      endcase
   end

   tscr_front u_front (
      .req_if        (req_if),
      .playhead_code (playhead_code_ff),
      .queue_full    (queue_full),
      .push          (push),
      .item          (front_item)
   );

   tscr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_valid),
      .pop_item  (queue_item)
   );

   tscr_engine #(
      .MaxClients (MaxClients)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (queue_valid),
      .item            (queue_item),
      .item_pop        (pop),
      .idle_timeout_ms (idle_timeout_ff),
      .rsp_if          (rsp_if)
   );

endmodule
